>>> rtl/core/bjsq_pkg.sv
package bjsq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam logic CMD_SUBMIT = 1'b0;
  localparam logic CMD_NEXT   = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [1:0] POL_ARRIVAL  = 2'd0;
  localparam logic [1:0] POL_RUNTIME  = 2'd1;
  localparam logic [1:0] POL_PRIORITY = 2'd2;

  localparam logic [1:0] RES_SUBMIT   = 2'd0;
  localparam logic [1:0] RES_FULL     = 2'd1;
  localparam logic [1:0] RES_EMPTY    = 2'd2;
  localparam logic [1:0] RES_DISPATCH = 2'd3;

  typedef struct packed {
    logic        command;
    logic [7:0]  job_id;
    logic [15:0] job_time;
    logic [7:0]  job_priority;
    logic [16:0] submit_sec;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  out_job_id;
    logic [15:0] out_job_time;
    logic [7:0]  out_priority;
    logic [4:0]  waiting_count;
    logic [19:0] expected_wait;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  job_id;
    logic [15:0] job_time;
    logic [7:0]  job_priority;
    logic [16:0] submit_sec;
    logic [15:0] order;
  } slot_t;

  typedef struct packed {
    logic       load;
    logic       wr_slot;
    logic       rd_en;
    logic       finish;
    logic [1:0] kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic slot_free;
  } dp_status_t;

  function automatic logic [16:0] job_key(input logic [1:0] policy, input slot_t s);
    logic [16:0] k;
    unique case (policy)
      POL_RUNTIME:  k = {1'b0, s.job_time};
      POL_PRIORITY: k = {9'd0, s.job_priority};
      default:      k = s.submit_sec;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/core/bjsq_ctrl.sv
module bjsq_ctrl #(
  parameter int QUEUE_DEPTH = bjsq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           in_command,
  input  bjsq_pkg::dp_status_t           dp_status,
  output bjsq_pkg::ctrl_cmd_t            cmd,
  output logic [$clog2(QUEUE_DEPTH)-1:0] idx,
  output logic                           busy
);
  import bjsq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FIND = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_LAST = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [1:0]       kind_r, kind_nxt;

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    kind_nxt    = kind_r;
    cmd         = '0;
    cmd.kind    = kind_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          idx_nxt  = '0;
          if (in_command == CMD_SUBMIT) begin
            if (dp_status.full) begin
              kind_nxt  = RES_FULL;
              state_nxt = S_DONE;
            end else begin
              kind_nxt  = RES_SUBMIT;
              state_nxt = S_FIND;
            end
          end else begin
            if (dp_status.empty) begin
              kind_nxt  = RES_EMPTY;
              state_nxt = S_DONE;
            end else begin
              kind_nxt  = RES_DISPATCH;
              state_nxt = S_SCAN;
            end
          end
        end
      end
      S_FIND: begin
        if (dp_status.slot_free) begin
          cmd.wr_slot = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (idx_r == IDX_W'(QUEUE_DEPTH - 1)) begin
          state_nxt = S_LAST;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_LAST: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      kind_r  <= RES_SUBMIT;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      kind_r  <= kind_nxt;
    end
  end

  assign idx  = idx_r;
  assign busy = (state_r != S_IDLE);

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not start work");

  a_find_only_when_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIND) |-> !dp_status.full)
    else $error("free slot search with a full table");

  a_scan_only_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !dp_status.empty)
    else $error("dispatch scan with no waiting job");

endmodule

>>> rtl/core/bjsq_dp.sv
module bjsq_dp #(
  parameter int QUEUE_DEPTH = bjsq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bjsq_pkg::in_item_t             in_item,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_wdata,
  input  bjsq_pkg::ctrl_cmd_t            cmd,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] idx,
  output bjsq_pkg::dp_status_t           dp_status,
  output logic                           out_strobe,
  output bjsq_pkg::out_item_t            out_result
);
  import bjsq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = 16 + CNT_W;

  slot_t            mem [QUEUE_DEPTH];
  slot_t            rd_data_r;
  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_idx_r;

  in_item_t         item_r;
  logic [1:0]       policy_r;
  logic [QUEUE_DEPTH-1:0] valid_r, valid_nxt;
  logic [15:0]      ctr_r, ctr_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic             best_found_r;
  logic [IDX_W-1:0] best_idx_r;
  logic [16:0]      best_key_r;
  logic [15:0]      best_age_r;
  slot_t            best_slot_r;

  logic [16:0]      cur_key;
  logic [15:0]      cur_age;
  logic             cur_better;

  logic             strobe_r;
  out_item_t        out_r, out_nxt;
  logic [31:0]      cnt_ext, sum_ext;
  slot_t            wr_slot_data;

  assign wr_slot_data = '{job_id:       item_r.job_id,
                          job_time:     item_r.job_time,
                          job_priority: item_r.job_priority,
                          submit_sec:   item_r.submit_sec,
                          order:        ctr_r};

  always_ff @(posedge clk) begin
    if (cmd.wr_slot) begin
      mem[idx] <= wr_slot_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[idx];
    end
  end

  assign cur_key    = job_key(policy_r, rd_data_r);
  assign cur_age    = ctr_r - rd_data_r.order;
  assign cur_better = !best_found_r || (cur_key < best_key_r) ||
                      ((cur_key == best_key_r) && (cur_age > best_age_r));

  always_comb begin
    valid_nxt = valid_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    ctr_nxt   = ctr_r;
    if (cmd.wr_slot) begin
      valid_nxt[idx] = 1'b1;
      sum_nxt        = sum_r + SUM_W'(item_r.job_time);
      cnt_nxt        = cnt_r + CNT_W'(1);
      ctr_nxt        = ctr_r + 16'd1;
    end
    if (cmd.finish && (cmd.kind == RES_DISPATCH)) begin
      valid_nxt[best_idx_r] = 1'b0;
      sum_nxt               = sum_r - SUM_W'(best_slot_r.job_time);
      cnt_nxt               = cnt_r - CNT_W'(1);
    end
  end

  always_comb begin
    cnt_ext = 32'(cnt_nxt);
    sum_ext = 32'(sum_nxt);
    out_nxt = '0;
    unique case (cmd.kind)
      RES_SUBMIT:   out_nxt.status = ST_OK;
      RES_FULL:     out_nxt.status = ST_FULL;
      RES_EMPTY:    out_nxt.status = ST_EMPTY;
      RES_DISPATCH: begin
        out_nxt.status       = ST_OK;
        out_nxt.out_job_id   = best_slot_r.job_id;
        out_nxt.out_job_time = best_slot_r.job_time;
        out_nxt.out_priority = best_slot_r.job_priority;
      end
    endcase
    out_nxt.waiting_count = (cnt_ext > 32'd31) ? 5'd31 : cnt_ext[4:0];
    out_nxt.expected_wait = (sum_ext > 32'hFFFFF) ? 20'hFFFFF : sum_ext[19:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r     <= POL_ARRIVAL;
      valid_r      <= '0;
      ctr_r        <= '0;
      sum_r        <= '0;
      cnt_r        <= '0;
      rd_vld_r     <= 1'b0;
      best_found_r <= 1'b0;
      strobe_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        policy_r <= cfg_wdata;
      end
      valid_r  <= valid_nxt;
      ctr_r    <= ctr_nxt;
      sum_r    <= sum_nxt;
      cnt_r    <= cnt_nxt;
      rd_vld_r <= cmd.rd_en && valid_r[idx];
      strobe_r <= cmd.finish;
      if (cmd.load) begin
        best_found_r <= 1'b0;
      end else if (rd_vld_r && cur_better) begin
        best_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= idx;
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (rd_vld_r && cur_better) begin
      best_idx_r  <= rd_idx_r;
      best_key_r  <= cur_key;
      best_age_r  <= cur_age;
      best_slot_r <= rd_data_r;
    end
    if (cmd.finish) begin
      out_r <= out_nxt;
    end
  end

  assign dp_status.full      = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign dp_status.empty     = (cnt_r == '0);
  assign dp_status.slot_free = !valid_r[idx];
  assign out_strobe          = strobe_r;
  assign out_result          = out_r;

  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(cnt_r))
    else $error("waiting count disagrees with valid slots");

  a_dispatch_has_winner: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && (cmd.kind == RES_DISPATCH)) |-> best_found_r)
    else $error("dispatch finished without a selected job");

  a_empty_means_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && (out_r.status == ST_EMPTY)) |-> (cnt_r == '0))
    else $error("empty status with jobs waiting");

endmodule

>>> rtl/core/batch_job_scheduler_queue.sv
// Submit: the controller searches for the lowest free slot, one slot per cycle, from
// index 0, writes the job there and then shows the result beat; full skips the search.
// Dispatch: every table entry is read from the job memory, one per cycle, followed by
// a final compare and a commit; with nothing waiting the scan is skipped.
// A new item is accepted in the same cycle its result beat is shown; the receiver
// cannot stall. Synchronous reset empties the table, zeroes the counters and policy.
module batch_job_scheduler_queue #(
  parameter int QUEUE_DEPTH = bjsq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bjsq_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output bjsq_pkg::out_item_t out_result,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_wdata
);
  import bjsq_pkg::*;

  ctrl_cmd_t                      cmd;
  dp_status_t                     dp_status;
  logic [$clog2(QUEUE_DEPTH)-1:0] idx;

  bjsq_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_item.command),
    .dp_status  (dp_status),
    .cmd        (cmd),
    .idx        (idx),
    .busy       (busy)
  );

  bjsq_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .idx        (idx),
    .dp_status  (dp_status),
    .out_strobe (out_strobe),
    .out_result (out_result)
  );

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bjsq_pkg::*;

  localparam logic [1:0] POL_SPARE = 2'd3;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 250;

  typedef enum logic {ROW_ITEM, ROW_POLICY} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    logic [1:0] policy;
    in_item_t   item;
    bit         typed;
    out_item_t  result;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_strobe;
  out_item_t out_result;
  logic      cfg_we;
  logic [1:0] cfg_wdata;

  always #5 clk = ~clk;

  batch_job_scheduler_queue dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_strobe(out_strobe),
    .out_result(out_result),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow of the job table and the scheduling policy.
  logic        held_valid [QUEUE_DEPTH_DEF];
  in_item_t    held_job [QUEUE_DEPTH_DEF];
  logic [15:0] held_seq [QUEUE_DEPTH_DEF];
  logic [15:0] seq_count;
  int unsigned wait_total;
  int unsigned wait_jobs;
  logic [1:0]  sched_policy;

  out_item_t pending_results[$];
  stim_row_t sent_rows[$];
  stim_row_t plan[$];
  int errors = 0;
  int burst_left = 0;

  function automatic void clear_schedule();
    int i;
    for (i = 0; i < QUEUE_DEPTH_DEF; i++) begin
      held_valid[i] = 1'b0;
    end
    seq_count = '0;
    wait_total = 0;
    wait_jobs = 0;
    sched_policy = POL_ARRIVAL;
  endfunction

  function automatic logic [16:0] sort_key(input in_item_t j);
    unique case (sched_policy)
      POL_RUNTIME:  return {1'b0, j.job_time};
      POL_PRIORITY: return {9'd0, j.job_priority};
      default:      return j.submit_sec;
    endcase
  endfunction

  function automatic out_item_t schedule_step(input in_item_t it);
    out_item_t   r;
    int          slot, best, i;
    logic [16:0] k, best_key;
    logic [15:0] age, best_age;
    r = '0;
    r.status = ST_OK;
    slot = -1;
    best = -1;
    best_key = '0;
    best_age = '0;
    if (it.command == CMD_SUBMIT) begin
      for (i = 0; i < QUEUE_DEPTH_DEF; i++) begin
        if (slot < 0 && !held_valid[i]) slot = i;
      end
      if (slot < 0) begin
        r.status = ST_FULL;
      end else begin
        held_job[slot] = it;
        held_seq[slot] = seq_count;
        held_valid[slot] = 1'b1;
        seq_count = seq_count + 16'd1;
        wait_total += it.job_time;
        wait_jobs++;
      end
    end else begin
      for (i = 0; i < QUEUE_DEPTH_DEF; i++) begin
        if (held_valid[i]) begin
          k = sort_key(held_job[i]);
          age = seq_count - held_seq[i];
          if (best < 0 || k < best_key || (k == best_key && age > best_age)) begin
            best = i;
            best_key = k;
            best_age = age;
          end
        end
      end
      if (best < 0) begin
        r.status = ST_EMPTY;
      end else begin
        held_valid[best] = 1'b0;
        r.out_job_id = held_job[best].job_id;
        r.out_job_time = held_job[best].job_time;
        r.out_priority = held_job[best].job_priority;
        wait_total -= held_job[best].job_time;
        wait_jobs--;
      end
    end
    r.waiting_count = wait_jobs > 31 ? 5'd31 : 5'(wait_jobs);
    r.expected_wait = wait_total > 32'hFFFFF ? 20'hFFFFF : 20'(wait_total);
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= 40) begin
        $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    stim_row_t row;
    out_item_t want;
    if (!rst_n) begin
      clear_schedule();
    end else begin
      if (cfg_we) sched_policy = cfg_wdata;
      if (out_strobe) begin
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= 40) begin
            $display("%0t unexpected result beat: expected none, actual %h", $time,
                     out_result);
          end
        end else begin
          want = pending_results.pop_front();
          check_field("status", want.status, out_result.status);
          check_field("out_job_id", want.out_job_id, out_result.out_job_id);
          check_field("out_job_time", want.out_job_time, out_result.out_job_time);
          check_field("out_priority", want.out_priority, out_result.out_priority);
          check_field("waiting_count", want.waiting_count, out_result.waiting_count);
          check_field("expected_wait", want.expected_wait, out_result.expected_wait);
        end
      end
      if (start && !busy) begin
        want = schedule_step(in_item);
        if (sent_rows.size() != 0) begin
          row = sent_rows.pop_front();
          if (row.typed) want = row.result;
        end
        pending_results.push_back(want);
      end
    end
  end

  function automatic in_item_t make_job(input logic cmd, input logic [7:0] id,
                                        input logic [15:0] t, input logic [7:0] p,
                                        input logic [16:0] a);
    in_item_t j;
    j.command = cmd;
    j.job_id = id;
    j.job_time = t;
    j.job_priority = p;
    j.submit_sec = a;
    return j;
  endfunction

  function automatic out_item_t status_only(input logic [1:0] st, input logic [4:0] cnt,
                                            input logic [19:0] wt);
    out_item_t r;
    r = '0;
    r.status = st;
    r.waiting_count = cnt;
    r.expected_wait = wt;
    return r;
  endfunction

  function automatic void add_item(input in_item_t it, input bit typed,
                                   input out_item_t result);
    stim_row_t r;
    r.kind = ROW_ITEM;
    r.policy = POL_ARRIVAL;
    r.item = it;
    r.typed = typed;
    r.result = result;
    plan.push_back(r);
  endfunction

  function automatic void add_policy(input logic [1:0] p);
    stim_row_t r;
    r.kind = ROW_POLICY;
    r.policy = p;
    r.item = '0;
    r.typed = 1'b0;
    r.result = '0;
    plan.push_back(r);
  endfunction

  function automatic in_item_t random_job(input int sub_pct);
    in_item_t j;
    j.command = ($urandom_range(0, 99) < sub_pct) ? CMD_SUBMIT : CMD_NEXT;
    j.job_id = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 2) == 0) begin
      j.job_time = 16'($urandom_range(0, 3));
      j.job_priority = 8'($urandom_range(0, 3));
      j.submit_sec = 17'($urandom_range(0, 3));
    end else begin
      j.job_time = 16'($urandom_range(0, 65535));
      j.job_priority = 8'($urandom_range(0, 255));
      j.submit_sec = 17'($urandom_range(0, 131071));
    end
    return j;
  endfunction

  task automatic send_row(input stim_row_t r);
    sent_rows.push_back(r);
    start <= 1'b1;
    in_item <= r.item;
    do @(posedge clk); while (busy);
  endtask

  task automatic pace(input bit allow_idle);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      if (allow_idle && $urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_policy(input logic [1:0] p);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    stim_row_t r;
    int n, phase, k;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;

    add_item(make_job(CMD_NEXT, 8'd0, 16'd0, 8'd0, 17'd0), 1'b1,
             status_only(ST_EMPTY, 5'd0, 20'd0));
    add_item(make_job(CMD_SUBMIT, 8'd255, 16'hFFFF, 8'd255, 17'd86399), 1'b1,
             status_only(ST_OK, 5'd1, 20'd65535));
    add_item(make_job(CMD_SUBMIT, 8'd0, 16'hFFFF, 8'd0, 17'd0), 1'b0, '0);
    add_item(make_job(CMD_SUBMIT, 8'd1, 16'hFFFF, 8'd128, 17'h1FFFF), 1'b0, '0);
    for (n = 3; n < 15; n++) begin
      add_item(make_job(CMD_SUBMIT, 8'(n), 16'hFFFF, 8'(n % 4), 17'((n * 7919) % 86400)),
               1'b0, '0);
    end
    add_item(make_job(CMD_SUBMIT, 8'd15, 16'hFFFF, 8'd3, 17'd40000), 1'b1,
             status_only(ST_OK, 5'd16, 20'd1048560));
    add_item(make_job(CMD_SUBMIT, 8'd99, 16'd1, 8'd0, 17'd1), 1'b1,
             status_only(ST_FULL, 5'd16, 20'd1048560));
    add_policy(POL_PRIORITY);
    add_item(make_job(CMD_NEXT, 8'd0, 16'd0, 8'd0, 17'd0), 1'b0, '0);
    add_policy(POL_RUNTIME);
    add_item(make_job(CMD_NEXT, 8'd0, 16'd0, 8'd0, 17'd0), 1'b0, '0);
    add_policy(POL_SPARE);
    add_item(make_job(CMD_NEXT, 8'd0, 16'd0, 8'd0, 17'd0), 1'b0, '0);
    add_policy(POL_ARRIVAL);
    add_item(make_job(CMD_NEXT, 8'd0, 16'd0, 8'd0, 17'd0), 1'b0, '0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[n]) begin
      if (plan[n].kind == ROW_POLICY) begin
        write_policy(plan[n].policy);
      end else begin
        send_row(plan[n]);
        pace(1'b1);
      end
    end

    for (phase = 0; phase < PHASES; phase++) begin
      unique case (phase)
        0: write_policy(POL_ARRIVAL);
        1: write_policy(POL_RUNTIME);
        2: write_policy(POL_PRIORITY);
        3: write_policy(POL_SPARE);
        default: write_policy(2'($urandom_range(0, 3)));
      endcase
      for (k = 0; k < PHASE_ITEMS; k++) begin
        r.kind = ROW_ITEM;
        r.policy = POL_ARRIVAL;
        r.item = random_job(((k / 40) % 2 == 0) ? 75 : 30);
        r.typed = 1'b0;
        r.result = '0;
        send_row(r);
        pace(phase != 2);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
